[design/nrc4_pkg.sv]
// Shared types, constants and helpers for the nibble RC4 stream cipher core.
package nrc4_pkg;

    // Permutation table geometry
    localparam int NIB_W      = 4;
    localparam int PERM_DEPTH = 16;

    // Field and register widths
    localparam int DATA_W    = 8;
    localparam int KEY_W     = 64;
    localparam int KLEN_W    = 5;
    localparam int CFG_IDX_W = 1;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_KEY_NIBBLES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH  = 1'd1;

    // Reset values of the configuration registers
    localparam logic [KEY_W-1:0]  KEY_RESET  = '0;
    localparam logic [KLEN_W-1:0] KLEN_RESET = 5'd16;

    // Sequencer step codes; the controller state is one of these
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_IDLE = 4'd0;
    localparam logic [OP_W-1:0] OP_FILL = 4'd1;
    localparam logic [OP_W-1:0] OP_K0   = 4'd2;
    localparam logic [OP_W-1:0] OP_K1   = 4'd3;
    localparam logic [OP_W-1:0] OP_K2   = 4'd4;
    localparam logic [OP_W-1:0] OP_K3   = 4'd5;
    localparam logic [OP_W-1:0] OP_B0   = 4'd6;
    localparam logic [OP_W-1:0] OP_B1   = 4'd7;
    localparam logic [OP_W-1:0] OP_B2   = 4'd8;
    localparam logic [OP_W-1:0] OP_B3   = 4'd9;
    localparam logic [OP_W-1:0] OP_OUT  = 4'd10;

    // Controller to datapath
    typedef struct packed {
        logic            load_in;
        logic [OP_W-1:0] op;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic cnt_last;
        logic last;
        logic out_free;
    } dp_sts_t;

    // Last key index used by the schedule; zero or over-long lengths act as 16
    function automatic logic [NIB_W-1:0] key_last_idx(input logic [KLEN_W-1:0] len);
        logic [KLEN_W-1:0] m1;
        m1 = len - KLEN_W'(1);
        if (len == '0 || len > KLEN_W'(PERM_DEPTH)) begin
            key_last_idx = NIB_W'(PERM_DEPTH - 1);
        end else begin
            key_last_idx = m1[NIB_W-1:0];
        end
    endfunction

endpackage

[design/nrc4_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module nrc4_ram #(
    parameter int WIDTH = nrc4_pkg::NIB_W,
    parameter int DEPTH = nrc4_pkg::PERM_DEPTH
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read returns old data on a same-address write
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/nrc4_ctrl.sv]
// Sequencer for key schedule and per-byte keystream steps.
module nrc4_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  nrc4_pkg::dp_sts_t sts,
    output nrc4_pkg::dp_cmd_t cmd
);

    logic [nrc4_pkg::OP_W-1:0] state_reg, state_next;
    logic                      need_reg, need_next;
    logic                      accept;

    assign in_ready = (state_reg == nrc4_pkg::OP_IDLE);
    assign accept   = in_valid && in_ready;

    assign cmd.load_in = accept;
    assign cmd.op      = state_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        need_next  = need_reg;
        case (state_reg)
            nrc4_pkg::OP_IDLE: begin
                if (accept) begin
                    state_next = need_reg ? nrc4_pkg::OP_FILL : nrc4_pkg::OP_B0;
                end
            end
            nrc4_pkg::OP_FILL: begin
                if (sts.cnt_last) begin
                    state_next = nrc4_pkg::OP_K0;
                end
            end
            nrc4_pkg::OP_K0: state_next = nrc4_pkg::OP_K1;
            nrc4_pkg::OP_K1: state_next = nrc4_pkg::OP_K2;
            nrc4_pkg::OP_K2: state_next = nrc4_pkg::OP_K3;
            nrc4_pkg::OP_K3: begin
                state_next = sts.cnt_last ? nrc4_pkg::OP_B0 : nrc4_pkg::OP_K0;
            end
            nrc4_pkg::OP_B0: state_next = nrc4_pkg::OP_B1;
            nrc4_pkg::OP_B1: state_next = nrc4_pkg::OP_B2;
            nrc4_pkg::OP_B2: state_next = nrc4_pkg::OP_B3;
            nrc4_pkg::OP_B3: state_next = nrc4_pkg::OP_OUT;
            nrc4_pkg::OP_OUT: begin
                if (sts.out_free) begin
                    state_next = nrc4_pkg::OP_IDLE;
                    need_next  = sts.last;
                end
            end
            default: state_next = nrc4_pkg::OP_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= nrc4_pkg::OP_IDLE;
            need_reg  <= 1'b1;
        end else begin
            state_reg <= state_next;
            need_reg  <= need_next;
        end
    end

endmodule

[design/nrc4_dp.sv]
// Datapath: key registers, permutation RAM, indices and output register.
module nrc4_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  nrc4_pkg::dp_cmd_t                   cmd,
    output nrc4_pkg::dp_sts_t                   sts,
    input  logic [nrc4_pkg::DATA_W-1:0]         in_data,
    input  logic                                in_last,
    input  logic                                cfg_we,
    input  logic [nrc4_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  logic [nrc4_pkg::KEY_W-1:0]          cfg_wdata,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [nrc4_pkg::DATA_W-1:0]         out_data,
    output logic                                out_last
);

    localparam int NW = nrc4_pkg::NIB_W;

    logic [nrc4_pkg::KEY_W-1:0]  key_reg;
    logic [nrc4_pkg::KLEN_W-1:0] klen_reg;
    logic [nrc4_pkg::DATA_W-1:0] din_reg;
    logic                        lin_reg;
    logic [NW-1:0] cnt_reg, kidx_reg, i_reg, j_reg, jn_reg, pa_reg, pb_reg, k_reg;
    logic          ov_reg;
    logic [nrc4_pkg::DATA_W-1:0] od_reg;
    logic          ol_reg;

    logic          ram_we;
    logic [NW-1:0] ram_wa, ram_wd, ram_ra, ram_rd;
    logic [NW-1:0] ip, kn, jsum, tsum, kval, klast;
    logic          out_free;

    nrc4_ram #(
        .WIDTH (NW),
        .DEPTH (nrc4_pkg::PERM_DEPTH)
    ) u_perm (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_wa),
        .wdata (ram_wd),
        .raddr (ram_ra),
        .rdata (ram_rd)
    );

    assign ip       = i_reg + NW'(1);
    assign kn       = key_reg[kidx_reg*NW +: NW];
    assign jsum     = j_reg + ram_rd + ((cmd.op == nrc4_pkg::OP_K1) ? kn : '0);
    assign tsum     = pa_reg + pb_reg;
    assign klast    = nrc4_pkg::key_last_idx(klen_reg);
    assign out_free = !ov_reg || out_ready;

    // Keystream lookup after the swap: swapped entries come from the registers
    assign kval = (tsum == jn_reg) ? pa_reg :
                  (tsum == ip)     ? pb_reg : ram_rd;

    assign sts.cnt_last = (cnt_reg == NW'(nrc4_pkg::PERM_DEPTH - 1));
    assign sts.last     = lin_reg;
    assign sts.out_free = out_free;

    // RAM port steering per step
    always_comb begin
        ram_we = 1'b0;
        ram_wa = cnt_reg;
        ram_wd = cnt_reg;
        ram_ra = ip;
        case (cmd.op)
            nrc4_pkg::OP_FILL: ram_we = 1'b1;
            nrc4_pkg::OP_K0:   ram_ra = cnt_reg;
            nrc4_pkg::OP_K1,
            nrc4_pkg::OP_B1:   ram_ra = jsum;
            nrc4_pkg::OP_K2: begin
                ram_we = 1'b1;
                ram_wd = ram_rd;
            end
            nrc4_pkg::OP_B2: begin
                ram_we = 1'b1;
                ram_wa = ip;
                ram_wd = ram_rd;
                ram_ra = pa_reg + ram_rd;
            end
            nrc4_pkg::OP_K3,
            nrc4_pkg::OP_B3: begin
                ram_we = 1'b1;
                ram_wa = jn_reg;
                ram_wd = pa_reg;
            end
            default: ram_ra = ip;
        endcase
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg  <= nrc4_pkg::KEY_RESET;
            klen_reg <= nrc4_pkg::KLEN_RESET;
        end else if (cfg_we) begin
            if (cfg_idx == nrc4_pkg::REG_KEY_NIBBLES) begin
                key_reg <= cfg_wdata;
            end
            if (cfg_idx == nrc4_pkg::REG_KEY_LENGTH) begin
                klen_reg <= cfg_wdata[nrc4_pkg::KLEN_W-1:0];
            end
        end
    end

    // Indices, counters and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            kidx_reg <= '0;
            i_reg    <= '0;
            j_reg    <= '0;
            ov_reg   <= 1'b0;
        end else begin
            // Output valid: set when a result loads, cleared when taken
            if (cmd.op == nrc4_pkg::OP_OUT && out_free) begin
                ov_reg <= 1'b1;
            end else if (out_ready) begin
                ov_reg <= 1'b0;
            end
            if (cmd.load_in) begin
                cnt_reg <= '0;
            end
            case (cmd.op)
                nrc4_pkg::OP_FILL: begin
                    cnt_reg  <= cnt_reg + NW'(1);
                    j_reg    <= '0;
                    kidx_reg <= '0;
                end
                nrc4_pkg::OP_K3: begin
                    cnt_reg  <= cnt_reg + NW'(1);
                    kidx_reg <= (kidx_reg == klast) ? '0 : kidx_reg + NW'(1);
                    if (sts.cnt_last) begin
                        i_reg <= '0;
                        j_reg <= '0;
                    end else begin
                        j_reg <= jn_reg;
                    end
                end
                nrc4_pkg::OP_B3: begin
                    i_reg <= ip;
                    j_reg <= jn_reg;
                end
                default: ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            din_reg <= in_data;
            lin_reg <= in_last;
        end
        case (cmd.op)
            nrc4_pkg::OP_K1,
            nrc4_pkg::OP_B1: begin
                pa_reg <= ram_rd;
                jn_reg <= jsum;
            end
            nrc4_pkg::OP_B2: pb_reg <= ram_rd;
            nrc4_pkg::OP_B3: k_reg  <= kval;
            nrc4_pkg::OP_OUT: begin
                if (out_free) begin
                    od_reg <= din_reg ^ {{(nrc4_pkg::DATA_W-NW){1'b0}}, k_reg};
                    ol_reg <= lin_reg;
                end
            end
            default: ;
        endcase
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;
    assign out_last  = ol_reg;

endmodule

[design/nibble_rc4_stream_cipher_core.sv]
// Per byte: once its input request is accepted the core steps through B0..B3, then loads the output register.
// A new input byte is taken only after the previous result has loaded; the single-read-port RAM sets the steps.
// First byte of a message adds a key schedule: identity fill of 16 entries, then 16 swaps, each K0..K3.
// Output stalls hold the sequencer in its output step until the result register frees up.
// Reset (aresetn low, synchronous): key 0, key length 16, indices 0, schedule pending, output empty.
// Top level of the nibble RC4 stream cipher core.
module nibble_rc4_stream_cipher_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input request channel
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,    // [7:0] data_in
    input  logic                               s_tlast,
    // result channel
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [7:0]                         m_tdata,    // [7:0] data_out
    output logic                               m_tlast,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [nrc4_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [nrc4_pkg::KEY_W-1:0]         cfg_data
);

    nrc4_pkg::dp_cmd_t cmd;
    nrc4_pkg::dp_sts_t sts;

    assign cfg_ready = 1'b1;

    nrc4_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    nrc4_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (s_tdata),
        .in_last   (s_tlast),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_idx   (cfg_index),
        .cfg_wdata (cfg_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

[tb/sv/nibble_rc4_stream_cipher_core_tb.sv]
// Self-checking testbench for the nibble RC4 stream cipher core: random traffic, key changes.
module nibble_rc4_stream_cipher_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DATA_W     = nrc4_pkg::DATA_W;
    localparam int CFG_IDX_W  = nrc4_pkg::CFG_IDX_W;
    localparam int KEY_W      = nrc4_pkg::KEY_W;
    localparam int KLEN_W     = nrc4_pkg::KLEN_W;
    localparam int NIB_W      = nrc4_pkg::NIB_W;
    localparam int PERM_DEPTH = nrc4_pkg::PERM_DEPTH;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              last;
    } byte_req_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [DATA_W-1:0]    s_tdata = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [DATA_W-1:0]    m_tdata;
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [KEY_W-1:0]     cfg_data = '0;

    // Bytes waiting to be sent, and cipher results still owed by the core
    byte_req_t pending_reqs[$];
    byte_req_t expected_cipher[$];

    // Request accepted at the last rising edge; the driver pops it at the falling edge
    bit req_taken = 1'b0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;

    // Predictor state: key registers, permutation, indices
    logic [KEY_W-1:0]  cfg_key = nrc4_pkg::KEY_RESET;
    logic [KLEN_W-1:0] cfg_len = nrc4_pkg::KLEN_RESET;
    logic [NIB_W-1:0]  perm[PERM_DEPTH];
    logic [NIB_W-1:0]  ks_i = '0;
    logic [NIB_W-1:0]  ks_j = '0;
    bit                sched_pending = 1'b1;

    nibble_rc4_stream_cipher_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case the core hangs
    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Key schedule: rebuild the permutation from identity, then clear the indices
    function automatic void run_key_schedule();
        int               len;
        int               kidx;
        logic [NIB_W-1:0] j;
        logic [NIB_W-1:0] t;
        len = int'(cfg_len);
        if (len == 0 || len > PERM_DEPTH) begin
            len = PERM_DEPTH;
        end
        for (int s = 0; s < PERM_DEPTH; s++) begin
            perm[s] = NIB_W'(s);
        end
        j = '0;
        for (int s = 0; s < PERM_DEPTH; s++) begin
            kidx = s % len;
            j = j + perm[s] + cfg_key[4*kidx +: 4];
            t = perm[s];
            perm[s] = perm[j];
            perm[j] = t;
        end
        ks_i = '0;
        ks_j = '0;
    endfunction

    // One keystream step; schedules first if a message is starting
    function automatic logic [DATA_W-1:0] encrypt_byte(input logic [DATA_W-1:0] din,
                                                       input logic lst);
        logic [NIB_W-1:0] ni;
        logic [NIB_W-1:0] nj;
        logic [NIB_W-1:0] t;
        logic [NIB_W-1:0] sum;
        if (sched_pending) begin
            run_key_schedule();
            sched_pending = 1'b0;
        end
        ni = ks_i + 1'b1;
        nj = ks_j + perm[ni];
        t = perm[ni];
        perm[ni] = perm[nj];
        perm[nj] = t;
        sum = perm[ni] + perm[nj];
        ks_i = ni;
        ks_j = nj;
        if (lst) begin
            sched_pending = 1'b1;
        end
        return din ^ {4'h0, perm[sum]};
    endfunction

    // Input acceptance feeds the predictor; results are checked in order
    always @(posedge aclk) begin : watch_proc
        byte_req_t exp_res;
        byte_req_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                exp_res.data = encrypt_byte(s_tdata, s_tlast);
                exp_res.last = s_tlast;
                expected_cipher.push_back(exp_res);
                req_taken = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                if (expected_cipher.size() == 0) begin
                    report_mismatch($sformatf("unexpected result data=%h last=%b",
                                              m_tdata, m_tlast));
                end else begin
                    got = expected_cipher.pop_front();
                    if (m_tdata !== got.data) begin
                        report_mismatch($sformatf("data_out %h, want %h", m_tdata, got.data));
                    end
                    if (m_tlast !== got.last) begin
                        report_mismatch($sformatf("last_out %b, want %b", m_tlast, got.last));
                    end
                end
            end
        end
    end

    // Driver: holds a request until taken, idles and stalls at random
    always @(negedge aclk) begin : drive_proc
        bit        was_taken;
        if (aresetn) begin
            was_taken = req_taken;
            if (req_taken) begin
                pending_reqs.delete(0);
                req_taken = 1'b0;
            end
            if (s_tvalid && !was_taken) begin
                // keep the current request on the bus
            end else if (pending_reqs.size() != 0 &&
                         $urandom_range(0, 99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_reqs[0].data;
                s_tlast  <= pending_reqs[0].last;
            end else begin
                s_tvalid <= 1'b0;
            end
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic push_byte(input logic [DATA_W-1:0] d, input logic lst);
        byte_req_t r;
        r.data = d;
        r.last = lst;
        pending_reqs.push_back(r);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == nrc4_pkg::REG_KEY_NIBBLES) begin
            cfg_key = val;
        end else if (idx == nrc4_pkg::REG_KEY_LENGTH) begin
            cfg_len = val[KLEN_W-1:0];
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Let every request and result drain, then allow a full key schedule to pass
    task automatic wait_quiet();
        while (pending_reqs.size() != 0 || expected_cipher.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic set_idling(input int mode);
        case (mode % 4)
            0: begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            1: begin
                send_idle_pct = 54;
                recv_stall_pct = 0;
            end
            2: begin
                send_idle_pct = 0;
                recv_stall_pct = 54;
            end
            default: begin
                send_idle_pct = 17;
                recv_stall_pct = 17;
            end
        endcase
    endtask

    // Messages of random length; the phase may end inside an open message
    task automatic queue_random_traffic(input int n_items);
        int left;
        int len;
        left = n_items;
        while (left > 0) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
            for (int b = 0; b < len && left > 0; b++) begin
                push_byte(DATA_W'($urandom_range(0, 255)), b == len - 1);
                left--;
            end
        end
    endtask

    // Random key and a length drawn mostly from the edges of its range
    task automatic pick_random_key();
        logic [KEY_W-1:0] lenword;
        write_reg(nrc4_pkg::REG_KEY_NIBBLES, {$urandom, $urandom});
        lenword = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: lenword[KLEN_W-1:0] = 5'd1;
            1: lenword[KLEN_W-1:0] = 5'd16;
            2: lenword[KLEN_W-1:0] = 5'd0;
            3: lenword[KLEN_W-1:0] = 5'd31;
            default: lenword[KLEN_W-1:0] = KLEN_W'($urandom_range(1, 16));
        endcase
        write_reg(nrc4_pkg::REG_KEY_LENGTH, lenword);
    endtask

    initial begin : stimulus
        for (int s = 0; s < PERM_DEPTH; s++) begin
            perm[s] = NIB_W'(s);
        end
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: reset key, data extremes, one-byte message, then an open message
        set_idling(0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h0F, 1'b0);
        push_byte(8'hF0, 1'b1);
        push_byte(8'hA5, 1'b1);
        push_byte(8'h3C, 1'b0);
        push_byte(8'hC3, 1'b0);
        wait_quiet();

        // Key change mid-message: the open message keeps its old schedule
        write_reg(nrc4_pkg::REG_KEY_NIBBLES, {KEY_W{1'b1}});
        write_reg(nrc4_pkg::REG_KEY_LENGTH, 64'd1);
        push_byte(8'h5A, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h80, 1'b1);
        wait_quiet();

        // Zero length acts as full length
        write_reg(nrc4_pkg::REG_KEY_NIBBLES, 64'h0123_4567_89AB_CDEF);
        write_reg(nrc4_pkg::REG_KEY_LENGTH, 64'hFFFF_FFFF_FFFF_FFE0);
        push_byte(8'h01, 1'b0);
        push_byte(8'h02, 1'b1);
        wait_quiet();

        // Over-long lengths act as full length
        write_reg(nrc4_pkg::REG_KEY_LENGTH, 64'd31);
        push_byte(8'h7F, 1'b0);
        push_byte(8'hFE, 1'b1);
        wait_quiet();
        write_reg(nrc4_pkg::REG_KEY_LENGTH, 64'd17);
        push_byte(8'h55, 1'b1);
        push_byte(8'hAA, 1'b1);
        wait_quiet();

        // Random phases, each under a new random key and one of four idling mixes
        for (int ph = 0; ph < 6; ph++) begin
            pick_random_key();
            set_idling(ph);
            queue_random_traffic(255);
            wait_quiet();
        end

        repeat (20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

[files.f]
design/nrc4_pkg.sv
design/nrc4_ram.sv
design/nrc4_ctrl.sv
design/nrc4_dp.sv
design/nibble_rc4_stream_cipher_core.sv
tb/sv/nibble_rc4_stream_cipher_core_tb.sv
